@@ rtl/core/tsfc_pkg.sv @@
`timescale 1ns / 1ps

package tsfc_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned BurstLen  = 4;
  localparam int unsigned IdxW      = $clog2(BurstLen);
  localparam int unsigned SumW      = SampleW + IdxW;
  localparam int unsigned ThrW      = 10;
  localparam int unsigned CoefW     = 32;
  localparam int unsigned ProdW     = CoefW + SampleW + 1;
  localparam int unsigned AccW      = ProdW + 1;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DispW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 72;

  localparam logic [ThrW-1:0]         ThrRst  = ThrW'(10);
  localparam logic signed [CoefW-1:0] KxxRst  = -32'sd659;
  localparam logic signed [CoefW-1:0] KxyRst  = -32'sd40331;
  localparam logic signed [CoefW-1:0] OffxRst = 32'sd36899452;
  localparam logic signed [CoefW-1:0] KyxRst  = 32'sd22837;
  localparam logic signed [CoefW-1:0] KyyRst  = 32'sd35;
  localparam logic signed [CoefW-1:0] OffyRst = -32'sd2889181;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGateThreshold = 3'd0,
    CfgCoefXFromX    = 3'd1,
    CfgCoefXFromY    = 3'd2,
    CfgOffsetX       = 3'd3,
    CfgCoefYFromX    = 3'd4,
    CfgCoefYFromY    = 3'd5,
    CfgOffsetY       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                     accepted;
    logic [SampleW-1:0]       raw_x;
    logic [SampleW-1:0]       raw_y;
    logic [SampleW-1:0]       mean_x;
    logic [SampleW-1:0]       mean_y;
    logic signed [ProdW-1:0]  p_xx;
    logic signed [ProdW-1:0]  p_xy;
    logic signed [ProdW-1:0]  p_yx;
    logic signed [ProdW-1:0]  p_yy;
  } burst_t;

  function automatic logic [SampleW-1:0] abs_diff(input logic [SampleW-1:0] a,
                                                  input logic [SampleW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DispW-1:0] sat_display(input logic signed [AccW-1:0] acc);
    if (acc[AccW-1]) begin
      sat_display = '0;
    end else if (|acc[AccW-2:FracBits+DispW]) begin
      sat_display = '1;
    end else begin
      sat_display = acc[FracBits+DispW-1:FracBits];
    end
  endfunction

endpackage

@@ rtl/core/touch_sample_filter_calibrate_top.sv @@
`timescale 1ns / 1ps

// Touch sample filter with affine calibration. Each input item is one raw
// X/Y ADC pair; every fourth item closes a burst and yields one result item
// carrying the spread-check flag, the second raw pair, the truncated
// four-sample means and, for an accepted burst, the Q16.16 affine-mapped
// display coordinate floored and saturated to 0..65535 (zero when rejected).
// One item is taken per cycle unless the output stalls; a burst's result is
// registered in b1_q after the four 32x10 multipliers and the spread check,
// then in out_q after the sum, offset and saturation. The user must write the
// configuration registers via the write port only while idle; not enforced.
module touch_sample_filter_calibrate_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_x [9:0], sample_y [19:10], zero [23:20]
  input  logic [tsfc_pkg::InDataW-1:0]      s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // raw_x [9:0], raw_y [19:10], mean_x [29:20], mean_y [39:30],
  // display_x [55:40], display_y [71:56]
  output logic [tsfc_pkg::OutDataW-1:0]     m_axis_tdata,
  // accepted [0]
  output logic                              m_axis_tuser,

  input  logic                              cfg_we_i,
  input  logic [tsfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsfc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned SW = tsfc_pkg::SampleW;
  localparam logic [tsfc_pkg::IdxW-1:0] LastSlot = tsfc_pkg::IdxW'(tsfc_pkg::BurstLen - 1);

  logic [tsfc_pkg::ThrW-1:0]         thr_q;
  logic signed [tsfc_pkg::CoefW-1:0] kxx_q, kxy_q, offx_q, kyx_q, kyy_q, offy_q;

  logic [SW-1:0]                 xbuf_q [tsfc_pkg::BurstLen-1];
  logic [SW-1:0]                 ybuf_q [tsfc_pkg::BurstLen-1];
  logic [tsfc_pkg::IdxW-1:0]     idx_q, idx_d;

  logic                          v1_q, v1_d;
  tsfc_pkg::burst_t              b1_q, b1_d;
  logic                          v2_q, v2_d;
  logic [tsfc_pkg::OutDataW-1:0] out_q, out_d;
  logic                          acc_ok_q, acc_ok_d;

  logic                          s1_en, s2_en, in_acc, burst_end;
  logic [SW-1:0]                 in_x, in_y;
  logic [tsfc_pkg::SumW-1:0]     sum_x, sum_y;
  logic signed [SW:0]            rx_s, ry_s;
  logic signed [tsfc_pkg::AccW-1:0] acc_x, acc_y;
  logic [tsfc_pkg::DispW-1:0]    disp_x, disp_y;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= tsfc_pkg::ThrRst;
      kxx_q  <= tsfc_pkg::KxxRst;
      kxy_q  <= tsfc_pkg::KxyRst;
      offx_q <= tsfc_pkg::OffxRst;
      kyx_q  <= tsfc_pkg::KyxRst;
      kyy_q  <= tsfc_pkg::KyyRst;
      offy_q <= tsfc_pkg::OffyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsfc_pkg::CfgGateThreshold: thr_q  <= cfg_data_i[tsfc_pkg::ThrW-1:0];
        tsfc_pkg::CfgCoefXFromX:    kxx_q  <= $signed(cfg_data_i);
        tsfc_pkg::CfgCoefXFromY:    kxy_q  <= $signed(cfg_data_i);
        tsfc_pkg::CfgOffsetX:       offx_q <= $signed(cfg_data_i);
        tsfc_pkg::CfgCoefYFromX:    kyx_q  <= $signed(cfg_data_i);
        tsfc_pkg::CfgCoefYFromY:    kyy_q  <= $signed(cfg_data_i);
        tsfc_pkg::CfgOffsetY:       offy_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  assign s2_en         = !v2_q || m_axis_tready;
  assign s1_en         = !v1_q || s2_en;
  assign s_axis_tready = s1_en;
  assign in_acc        = s_axis_tvalid && s1_en;
  assign burst_end     = in_acc && (idx_q == LastSlot);

  assign in_x = s_axis_tdata[SW-1:0];
  assign in_y = s_axis_tdata[2*SW-1:SW];

  always_comb begin
    idx_d = idx_q;
    if (in_acc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (s1_en) begin
      v1_d = burst_end;
    end
    v2_d = v2_q;
    if (s2_en) begin
      v2_d = v1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      v1_q  <= v1_d;
      v2_q  <= v2_d;
    end
  end

  // Sample buffer; the closing pair is used straight from the input
  always_ff @(posedge clk_i) begin
    if (in_acc && (idx_q != LastSlot)) begin
      xbuf_q[idx_q] <= in_x;
      ybuf_q[idx_q] <= in_y;
    end
  end

  // Stage 1: spread check, means, products
  assign rx_s = $signed({1'b0, xbuf_q[1]});
  assign ry_s = $signed({1'b0, ybuf_q[1]});

  always_comb begin
    sum_x = tsfc_pkg::SumW'(xbuf_q[0]) + tsfc_pkg::SumW'(xbuf_q[1])
          + tsfc_pkg::SumW'(xbuf_q[2]) + tsfc_pkg::SumW'(in_x);
    sum_y = tsfc_pkg::SumW'(ybuf_q[0]) + tsfc_pkg::SumW'(ybuf_q[1])
          + tsfc_pkg::SumW'(ybuf_q[2]) + tsfc_pkg::SumW'(in_y);
    b1_d.accepted = (tsfc_pkg::abs_diff(xbuf_q[0], xbuf_q[1]) <= thr_q) &&
                    (tsfc_pkg::abs_diff(xbuf_q[2], in_x)      <= thr_q) &&
                    (tsfc_pkg::abs_diff(ybuf_q[0], ybuf_q[1]) <= thr_q) &&
                    (tsfc_pkg::abs_diff(ybuf_q[2], in_y)      <= thr_q);
    b1_d.raw_x  = xbuf_q[1];
    b1_d.raw_y  = ybuf_q[1];
    b1_d.mean_x = sum_x[tsfc_pkg::SumW-1:tsfc_pkg::IdxW];
    b1_d.mean_y = sum_y[tsfc_pkg::SumW-1:tsfc_pkg::IdxW];
    b1_d.p_xx   = tsfc_pkg::ProdW'(kxx_q) * tsfc_pkg::ProdW'(rx_s);
    b1_d.p_xy   = tsfc_pkg::ProdW'(kxy_q) * tsfc_pkg::ProdW'(ry_s);
    b1_d.p_yx   = tsfc_pkg::ProdW'(kyx_q) * tsfc_pkg::ProdW'(rx_s);
    b1_d.p_yy   = tsfc_pkg::ProdW'(kyy_q) * tsfc_pkg::ProdW'(ry_s);
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && burst_end) begin
      b1_q <= b1_d;
    end
  end

  // Stage 2: sum, offset, floor and saturate
  always_comb begin
    acc_x = tsfc_pkg::AccW'(b1_q.p_xx) + tsfc_pkg::AccW'(b1_q.p_xy)
          + tsfc_pkg::AccW'(offx_q);
    acc_y = tsfc_pkg::AccW'(b1_q.p_yx) + tsfc_pkg::AccW'(b1_q.p_yy)
          + tsfc_pkg::AccW'(offy_q);
    disp_x = b1_q.accepted ? tsfc_pkg::sat_display(acc_x) : '0;
    disp_y = b1_q.accepted ? tsfc_pkg::sat_display(acc_y) : '0;
    out_d = {disp_y, disp_x, b1_q.mean_y, b1_q.mean_x, b1_q.raw_y, b1_q.raw_x};
    acc_ok_d = b1_q.accepted;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && v1_q) begin
      out_q    <= out_d;
      acc_ok_q <= acc_ok_d;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = acc_ok_q;

`ifndef SYNTHESIS
  a_stall_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q))
    else $error("input stalled with a free stage");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[tsfc_pkg::OutDataW-1:4*SW] == '0))
    else $error("rejected burst with nonzero display coordinate");

  a_burst_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_en && v1_d) |-> (idx_q == LastSlot))
    else $error("burst closed before the last slot");
`endif

endmodule
